/* rtl/core/sequence_and_latency_monitor_defines.svh */
// Assertion macros for the sequence and latency monitor.
// Included by modules that carry concurrent assertions.
`ifndef SEQUENCE_AND_LATENCY_MONITOR_DEFINES_SVH
`define SEQUENCE_AND_LATENCY_MONITOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SLM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Plain condition that holds whenever out of reset.
`define SLM_CHECK(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

/* rtl/core/slm_pkg.sv */
// Package for the sequence and latency monitor: codes, records and command types.
// No dependencies.
`default_nettype none
package slm_pkg;
  localparam int unsigned DivSteps = 64;

  // Window counter slots
  localparam int unsigned WinArrivals = 0;
  localparam int unsigned WinFrames   = 1;
  localparam int unsigned WinGap      = 2;
  localparam int unsigned WinDup      = 3;
  localparam int unsigned WinReorder  = 4;
  localparam int unsigned WinSamples  = 5;

  typedef enum logic [1:0] {
    OP_ARRIVAL = 2'd0, OP_FRAME = 2'd1, OP_CLOSE = 2'd2, OP_READ = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0, KIND_WINDOW = 2'd1, KIND_TOTAL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CLS_FIRST = 2'd0, CLS_ADVANCE = 2'd1, CLS_DUPLICATE = 2'd2, CLS_REORDER = 2'd3
  } cls_e;

  typedef enum logic [3:0] {
    SEL_ARRIVALS = 4'd0, SEL_FRAMES = 4'd1, SEL_GAP = 4'd2, SEL_DUP = 4'd3,
    SEL_REORDER = 4'd4, SEL_LATSUM = 4'd5, SEL_SAMPLES = 4'd6, SEL_MIN = 4'd7,
    SEL_MAX = 4'd8, SEL_FUTURE = 4'd9, SEL_FUTFLAG = 4'd10
  } sel_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] sequence_number;
    logic [63:0] send_stamp;
    logic [63:0] receive_stamp;
    logic [3:0]  stat_select;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [1:0]  sequence_class;
    logic        future_stamp;
    logic [31:0] gap_count;
    logic [63:0] latency_value;
    logic [63:0] window_min_latency;
    logic [63:0] window_max_latency;
    logic [31:0] window_arrivals;
    logic [31:0] window_frames;
    logic [31:0] window_duplicates;
    logic [31:0] window_reorders;
    logic [63:0] stat_value;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch input transaction
    logic execute;   // apply update and build result
    logic div_start; // load divider
    logic div_step;  // one restoring step
    logic div_done;  // write quotient into result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_arrival;
    logic is_close;
    logic div_last;
  } status_t;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage
`default_nettype wire

/* rtl/core/slm_if.sv */
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type given as parameter.
`default_nettype none
interface slm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/slm_ctrl.sv */
// Controller state machine of the monitor.
// Depends on slm_pkg and sequence_and_latency_monitor_defines.svh.
`default_nettype none
`include "sequence_and_latency_monitor_defines.svh"
module slm_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  slm_pkg::status_t  status_i,
  output slm_pkg::cmd_t     cmd_o
);
  slm_pkg::state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one transaction
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      slm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = slm_pkg::ST_EXEC;
        end
      end
      slm_pkg::ST_EXEC: begin
        cmd_o.execute = 1'b1;
        if (status_i.is_arrival) begin
          state_d = slm_pkg::ST_IDLE;
        end else if (status_i.is_close) begin
          cmd_o.div_start = 1'b1;
          state_d = slm_pkg::ST_DIV;
        end else begin
          state_d = slm_pkg::ST_OUT;
        end
      end
      slm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          cmd_o.div_done = 1'b1;
          state_d = slm_pkg::ST_OUT;
        end
      end
      slm_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = slm_pkg::ST_IDLE;
        end
      end
      default: state_d = slm_pkg::ST_IDLE;
    endcase
  end

  `SLM_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != slm_pkg::ST_IDLE) |-> !in_ready_o, "accept while busy")
  `SLM_ASSERT(a_div_follows, clk_i, rst_ni, cmd_o.div_start |=> (state_q == slm_pkg::ST_DIV), "divider not entered")
  `SLM_ASSERT(a_out_holds, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
endmodule
`default_nettype wire

/* rtl/core/slm_datapath.sv */
// Datapath of the monitor: counters, classification, divider, result register.
// Depends on slm_pkg and sequence_and_latency_monitor_defines.svh.
`default_nettype none
`include "sequence_and_latency_monitor_defines.svh"
module slm_datapath (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  slm_pkg::in_item_t  in_i,
  input  slm_pkg::cmd_t      cmd_i,
  output slm_pkg::status_t   status_o,
  output slm_pkg::out_item_t out_o
);
  localparam int unsigned CntW = $clog2(slm_pkg::DivSteps + 1);

  slm_pkg::in_item_t  item_q;
  slm_pkg::out_item_t res_q, res_d;

  logic        have_prev_q, have_prev_d;
  logic [31:0] prev_q, prev_d;
  logic [63:0] lt_q [10];
  logic [63:0] lt_d [10];
  logic        fut_seen_q, fut_seen_d;
  logic [31:0] wn_q [6];
  logic [31:0] wn_d [6];
  logic [63:0] wsum_q, wsum_d, wmin_q, wmin_d, wmax_q, wmax_d;

  // Divider state
  logic [63:0]     dq_q, dr_q;
  logic [31:0]     dd_q;
  logic [CntW-1:0] dcnt_q;
  logic            dzero_q;
  logic [64:0]     trial;
  logic [63:0]     rem_sh;

  logic        fut;
  logic [63:0] lat;
  logic [31:0] gap;
  logic [1:0]  cls;

  // Capture input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_i;
    end
  end

  assign status_o = '{
    is_arrival: (item_q.operation == slm_pkg::OP_ARRIVAL),
    is_close:   (item_q.operation == slm_pkg::OP_CLOSE),
    div_last:   (dcnt_q == CntW'(slm_pkg::DivSteps - 1))
  };

  // Classify frame and derive latency
  always_comb begin
    fut = item_q.send_stamp > item_q.receive_stamp;
    lat = fut ? 64'd0 : item_q.receive_stamp - item_q.send_stamp;
    gap = '0;
    if (!have_prev_q) begin
      cls = slm_pkg::CLS_FIRST;
    end else if (item_q.sequence_number == prev_q) begin
      cls = slm_pkg::CLS_DUPLICATE;
    end else if (item_q.sequence_number > prev_q) begin
      cls = slm_pkg::CLS_ADVANCE;
      gap = item_q.sequence_number - prev_q - 32'd1;
    end else begin
      cls = slm_pkg::CLS_REORDER;
    end
  end

  // Compute next state and result
  always_comb begin
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    lt_d        = lt_q;
    fut_seen_d  = fut_seen_q;
    wn_d        = wn_q;
    wsum_d      = wsum_q;
    wmin_d      = wmin_q;
    wmax_d      = wmax_q;
    res_d       = res_q;
    if (cmd_i.execute) begin
      res_d = '0;
      case (item_q.operation)
        slm_pkg::OP_ARRIVAL: begin
          lt_d[slm_pkg::SEL_ARRIVALS] = lt_q[slm_pkg::SEL_ARRIVALS] + 64'd1;
          wn_d[slm_pkg::WinArrivals] = slm_pkg::sat_add32(wn_q[slm_pkg::WinArrivals], 32'd1);
        end
        slm_pkg::OP_FRAME: begin
          unique case (cls)
            slm_pkg::CLS_FIRST: begin
              have_prev_d = 1'b1;
              prev_d = item_q.sequence_number;
            end
            slm_pkg::CLS_DUPLICATE: begin
              lt_d[slm_pkg::SEL_DUP] = lt_q[slm_pkg::SEL_DUP] + 64'd1;
              wn_d[slm_pkg::WinDup] = slm_pkg::sat_add32(wn_q[slm_pkg::WinDup], 32'd1);
            end
            slm_pkg::CLS_ADVANCE: begin
              lt_d[slm_pkg::SEL_GAP] = lt_q[slm_pkg::SEL_GAP] + {32'd0, gap};
              wn_d[slm_pkg::WinGap] = slm_pkg::sat_add32(wn_q[slm_pkg::WinGap], gap);
              prev_d = item_q.sequence_number;
            end
            default: begin
              lt_d[slm_pkg::SEL_REORDER] = lt_q[slm_pkg::SEL_REORDER] + 64'd1;
              wn_d[slm_pkg::WinReorder] =
                slm_pkg::sat_add32(wn_q[slm_pkg::WinReorder], 32'd1);
            end
          endcase
          if (!fut) begin
            lt_d[slm_pkg::SEL_LATSUM]  = lt_q[slm_pkg::SEL_LATSUM] + lat;
            lt_d[slm_pkg::SEL_SAMPLES] = lt_q[slm_pkg::SEL_SAMPLES] + 64'd1;
            wsum_d  = wsum_q + lat;
            wn_d[slm_pkg::WinSamples] = slm_pkg::sat_add32(wn_q[slm_pkg::WinSamples], 32'd1);
            if (lat > lt_q[slm_pkg::SEL_MAX]) lt_d[slm_pkg::SEL_MAX] = lat;
            if (lt_q[slm_pkg::SEL_MIN] == 64'd0 || lat < lt_q[slm_pkg::SEL_MIN]) begin
              lt_d[slm_pkg::SEL_MIN] = lat;
            end
            if (lat > wmax_q) wmax_d = lat;
            if (wmin_q == 64'd0 || lat < wmin_q) wmin_d = lat;
          end else begin
            lt_d[slm_pkg::SEL_FUTURE] = lt_q[slm_pkg::SEL_FUTURE] + 64'd1;
            fut_seen_d = 1'b1;
          end
          lt_d[slm_pkg::SEL_FRAMES] = lt_q[slm_pkg::SEL_FRAMES] + 64'd1;
          wn_d[slm_pkg::WinFrames] = slm_pkg::sat_add32(wn_q[slm_pkg::WinFrames], 32'd1);
          res_d.report_kind    = slm_pkg::KIND_FRAME;
          res_d.sequence_class = cls;
          res_d.future_stamp   = fut;
          res_d.gap_count      = gap;
          res_d.latency_value  = lat;
        end
        slm_pkg::OP_CLOSE: begin
          res_d.report_kind        = slm_pkg::KIND_WINDOW;
          res_d.gap_count          = wn_q[slm_pkg::WinGap];
          res_d.window_min_latency = wmin_q;
          res_d.window_max_latency = wmax_q;
          res_d.window_arrivals    = wn_q[slm_pkg::WinArrivals];
          res_d.window_frames      = wn_q[slm_pkg::WinFrames];
          res_d.window_duplicates  = wn_q[slm_pkg::WinDup];
          res_d.window_reorders    = wn_q[slm_pkg::WinReorder];
          for (int i = 0; i < 6; i++) wn_d[i] = '0;
          wsum_d = '0;
          wmin_d = '0;
          wmax_d = '0;
        end
        default: begin
          res_d.report_kind = slm_pkg::KIND_TOTAL;
          if (item_q.stat_select < slm_pkg::SEL_FUTFLAG) begin
            res_d.stat_value = lt_q[item_q.stat_select];
          end else if (item_q.stat_select == slm_pkg::SEL_FUTFLAG) begin
            res_d.stat_value = {63'd0, fut_seen_q};
          end
        end
      endcase
    end
    if (cmd_i.div_done) begin
      res_d.latency_value = dzero_q ? 64'd0 : {dq_q[62:0], ~trial[64]};
    end
  end

  // Hold monitor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      fut_seen_q  <= 1'b0;
      wsum_q      <= '0;
      wmin_q      <= '0;
      wmax_q      <= '0;
      for (int i = 0; i < 10; i++) lt_q[i] <= '0;
      for (int i = 0; i < 6; i++) wn_q[i] <= '0;
    end else begin
      have_prev_q <= have_prev_d;
      prev_q      <= prev_d;
      fut_seen_q  <= fut_seen_d;
      wsum_q      <= wsum_d;
      wmin_q      <= wmin_d;
      wmax_q      <= wmax_d;
      lt_q        <= lt_d;
      wn_q        <= wn_d;
    end
  end

  // Advance restoring divider one bit a step, dividend shifted through dq
  assign rem_sh = {dr_q[62:0], dq_q[63]};
  assign trial  = {1'b0, rem_sh} - {33'd0, dd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q    <= wsum_q;
      dr_q    <= '0;
      dd_q    <= wn_q[slm_pkg::WinSamples];
      dzero_q <= (wn_q[slm_pkg::WinSamples] == 32'd0);
    end else if (cmd_i.div_step) begin
      dq_q <= {dq_q[62:0], ~trial[64]};
      dr_q <= trial[64] ? rem_sh : trial[63:0];
    end
  end

  // Register result
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o = res_q;

  `SLM_ASSERT(a_window_clears, clk_i, rst_ni, (cmd_i.execute && status_o.is_close) |=> (wsum_q == 64'd0 && wmin_q == 64'd0), "window not cleared")
  `SLM_ASSERT(a_minmax, clk_i, rst_ni, (wmin_q != 64'd0) |-> (wmin_q <= wmax_q), "window min above max")
  `SLM_CHECK(a_prev_set, clk_i, rst_ni, have_prev_q || prev_q == 32'd0, "previous set without flag")
endmodule
`default_nettype wire

/* rtl/core/sequence_and_latency_monitor.sv */
// An arrival produces no report. A window close reports the mean latency by restoring division,
// one restoring-division bit a cycle over the 64-bit latency sum. A new transaction is taken
// only when idle, once the last one is executed and any report it made has been accepted.
// Reset: rst_ni low asynchronously clears every counter, min/max and sequence history.
// Depends on slm_pkg, slm_if, slm_ctrl, slm_datapath.
`default_nettype none
module sequence_and_latency_monitor (
  input  wire clk_i,
  input  wire rst_ni,
  slm_if.sink   in_if,
  slm_if.source out_if
);
  slm_pkg::cmd_t    cmd;
  slm_pkg::status_t status;

  slm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  slm_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_if.data),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_if.data)
  );
endmodule
`default_nettype wire

/* tb/tb_sequence_and_latency_monitor.sv */
// Self-checking testbench for the sequence and latency monitor.
// Depends on slm_pkg, slm_if and the monitor RTL; predicts every report in a local model.
`default_nettype none
module tb_sequence_and_latency_monitor;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  slm_if #(.payload_t(slm_pkg::in_item_t))  frame_ch ();
  slm_if #(.payload_t(slm_pkg::out_item_t)) report_ch ();

  sequence_and_latency_monitor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (frame_ch.sink),
    .out_if (report_ch.source)
  );

  // Free-running clock
  always #5 clk_i = ~clk_i;

  // Predictor state
  bit          mdl_have_prev;
  bit [31:0]   mdl_prev_seq;
  bit [63:0]   mdl_life [10];
  bit          mdl_future_seen;
  bit [31:0]   mdl_win [6];
  bit [63:0]   mdl_win_sum;
  bit [63:0]   mdl_win_min;
  bit [63:0]   mdl_win_max;

  slm_pkg::out_item_t pending_reports [$];
  int unsigned mismatch_count = 0;
  longint      cycle_count = 0;
  bit          quiet_phase = 1'b0;

  localparam longint CycleLimit = 2_000_000;

  // Bump a window counter, holding at the top
  function automatic bit [31:0] win_add(bit [31:0] a, bit [31:0] b);
    bit [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic clear_model();
    mdl_have_prev = 0;
    mdl_prev_seq = 0;
    mdl_future_seen = 0;
    foreach (mdl_life[i]) mdl_life[i] = 0;
    foreach (mdl_win[i]) mdl_win[i] = 0;
    mdl_win_sum = 0;
    mdl_win_min = 0;
    mdl_win_max = 0;
  endtask

  // Apply one transaction to the predictor and queue the report it causes
  task automatic predict_report(slm_pkg::in_item_t it);
    slm_pkg::out_item_t r;
    bit [63:0] lat;
    r = '0;
    lat = 0;
    case (slm_pkg::op_e'(it.operation))
      slm_pkg::OP_ARRIVAL: begin
        mdl_life[slm_pkg::SEL_ARRIVALS]++;
        mdl_win[slm_pkg::WinArrivals] = win_add(mdl_win[slm_pkg::WinArrivals], 1);
        return;
      end
      slm_pkg::OP_FRAME: begin
        r.report_kind = slm_pkg::KIND_FRAME;
        if (!mdl_have_prev) begin
          r.sequence_class = slm_pkg::CLS_FIRST;
          mdl_have_prev = 1;
          mdl_prev_seq = it.sequence_number;
        end else if (it.sequence_number == mdl_prev_seq) begin
          r.sequence_class = slm_pkg::CLS_DUPLICATE;
          mdl_life[slm_pkg::SEL_DUP]++;
          mdl_win[slm_pkg::WinDup] = win_add(mdl_win[slm_pkg::WinDup], 1);
        end else if (it.sequence_number > mdl_prev_seq) begin
          r.sequence_class = slm_pkg::CLS_ADVANCE;
          r.gap_count = it.sequence_number - mdl_prev_seq - 32'd1;
          mdl_life[slm_pkg::SEL_GAP] += 64'(r.gap_count);
          mdl_win[slm_pkg::WinGap] = win_add(mdl_win[slm_pkg::WinGap], r.gap_count);
          mdl_prev_seq = it.sequence_number;
        end else begin
          r.sequence_class = slm_pkg::CLS_REORDER;
          mdl_life[slm_pkg::SEL_REORDER]++;
          mdl_win[slm_pkg::WinReorder] = win_add(mdl_win[slm_pkg::WinReorder], 1);
        end
        if (it.send_stamp > it.receive_stamp) begin
          r.future_stamp = 1;
          mdl_life[slm_pkg::SEL_FUTURE]++;
          mdl_future_seen = 1;
        end else begin
          lat = it.receive_stamp - it.send_stamp;
          r.latency_value = lat;
          mdl_life[slm_pkg::SEL_LATSUM] += lat;
          mdl_life[slm_pkg::SEL_SAMPLES]++;
          mdl_win_sum += lat;
          mdl_win[slm_pkg::WinSamples] = win_add(mdl_win[slm_pkg::WinSamples], 1);
          if (lat > mdl_life[slm_pkg::SEL_MAX]) mdl_life[slm_pkg::SEL_MAX] = lat;
          if (mdl_life[slm_pkg::SEL_MIN] == 0 || lat < mdl_life[slm_pkg::SEL_MIN])
            mdl_life[slm_pkg::SEL_MIN] = lat;
          if (lat > mdl_win_max) mdl_win_max = lat;
          if (mdl_win_min == 0 || lat < mdl_win_min) mdl_win_min = lat;
        end
        mdl_life[slm_pkg::SEL_FRAMES]++;
        mdl_win[slm_pkg::WinFrames] = win_add(mdl_win[slm_pkg::WinFrames], 1);
      end
      slm_pkg::OP_CLOSE: begin
        r.report_kind = slm_pkg::KIND_WINDOW;
        r.gap_count = mdl_win[slm_pkg::WinGap];
        r.latency_value = (mdl_win[slm_pkg::WinSamples] != 0)
                          ? mdl_win_sum / 64'(mdl_win[slm_pkg::WinSamples]) : 64'd0;
        r.window_min_latency = mdl_win_min;
        r.window_max_latency = mdl_win_max;
        r.window_arrivals = mdl_win[slm_pkg::WinArrivals];
        r.window_frames = mdl_win[slm_pkg::WinFrames];
        r.window_duplicates = mdl_win[slm_pkg::WinDup];
        r.window_reorders = mdl_win[slm_pkg::WinReorder];
        foreach (mdl_win[i]) mdl_win[i] = 0;
        mdl_win_sum = 0;
        mdl_win_min = 0;
        mdl_win_max = 0;
      end
      default: begin
        r.report_kind = slm_pkg::KIND_TOTAL;
        if (it.stat_select < slm_pkg::SEL_FUTFLAG) r.stat_value = mdl_life[it.stat_select];
        else if (it.stat_select == slm_pkg::SEL_FUTFLAG) r.stat_value = 64'(mdl_future_seen);
        else r.stat_value = 0;
      end
    endcase
    pending_reports.push_back(r);
  endtask

  // Offer one transaction, with a random gap outside the quiet phase, and wait for acceptance
  task automatic send_item(slm_pkg::in_item_t it);
    while (!quiet_phase && $urandom_range(99) < 8) begin
      frame_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.data <= it;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    predict_report(it);
  endtask

  function automatic slm_pkg::in_item_t make_item(slm_pkg::op_e op, bit [31:0] sq,
                                                  bit [63:0] tx, bit [63:0] rx,
                                                  bit [3:0] sel);
    slm_pkg::in_item_t it;
    it.operation = op;
    it.sequence_number = sq;
    it.send_stamp = tx;
    it.receive_stamp = rx;
    it.stat_select = sel;
    return it;
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic read_all_totals();
    for (int s = 0; s < 16; s++) send_item(make_item(slm_pkg::OP_READ, 0, 0, 0, s[3:0]));
  endtask

  // Directed: extremes, every class, future stamp, empty window
  task automatic test_directed();
    send_item(make_item(slm_pkg::OP_CLOSE, 0, 0, 0, 0));
    send_item(make_item(slm_pkg::OP_ARRIVAL, '1, '1, '1, '1));
    send_item(make_item(slm_pkg::OP_FRAME, 32'd10, 64'd100, 64'd100, 0));
    send_item(make_item(slm_pkg::OP_FRAME, 32'd10, 64'd5, 64'd50, 0));
    send_item(make_item(slm_pkg::OP_FRAME, 32'd14, 64'd0, '1, 0));
    send_item(make_item(slm_pkg::OP_FRAME, 32'd3, '1, 64'd0, 0));
    send_item(make_item(slm_pkg::OP_FRAME, 32'hFFFF_FFFF, 64'd7, 64'd9, 0));
    send_item(make_item(slm_pkg::OP_FRAME, 32'd0, 64'd1, 64'd1, 0));
    read_all_totals();
    send_item(make_item(slm_pkg::OP_CLOSE, 0, 0, 0, 0));
    send_item(make_item(slm_pkg::OP_CLOSE, 0, 0, 0, 0));
  endtask

  // Random: mostly near-in-order frames, some arrivals, closes and reads
  task automatic test_random(int n);
    bit [31:0] sq;
    bit [63:0] tx;
    slm_pkg::in_item_t it;
    sq = $urandom();
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) quiet_phase = 1'b1;
      if (i == n / 2) quiet_phase = 1'b0;
      case ($urandom_range(19))
        0, 1, 2: it = make_item(slm_pkg::OP_ARRIVAL, $urandom(), rand64(), rand64(),
                                4'($urandom()));
        3: it = make_item(slm_pkg::OP_CLOSE, $urandom(), rand64(), rand64(), 4'($urandom()));
        4, 5: it = make_item(slm_pkg::OP_READ, $urandom(), rand64(), rand64(),
                             4'($urandom()));
        6: it = make_item(slm_pkg::OP_FRAME, $urandom(), rand64(), rand64(), 4'($urandom()));
        default: begin
          case ($urandom_range(9))
            0: ;
            1: sq = sq - $urandom_range(1, 5);
            2: sq = sq + $urandom();
            default: sq = sq + $urandom_range(1, 3);
          endcase
          tx = rand64();
          it = make_item(slm_pkg::OP_FRAME, sq, tx,
                         ($urandom_range(9) == 0) ? tx - 64'($urandom_range(1, 1000))
                                                  : tx + 64'($urandom_range(0, 100000)),
                         4'($urandom()));
        end
      endcase
      send_item(it);
    end
    read_all_totals();
    send_item(make_item(slm_pkg::OP_CLOSE, 0, 0, 0, 0));
  endtask

  // Result side: random stalls outside the quiet phase, compare against oldest prediction
  always @(posedge clk_i) begin
    slm_pkg::out_item_t e;
    slm_pkg::out_item_t a;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (report_ch.valid && report_ch.ready) begin
        a = report_ch.data;
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected report %h", a);
        end else begin
          e = pending_reports.pop_front();
          if (a !== e) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("report mismatch: expected %h actual %h", e, a);
          end
        end
      end
      report_ch.ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 8);
    end else begin
      report_ch.ready <= 1'b0;
    end
  end

  // Timeout guard
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    frame_ch.valid = 1'b0;
    frame_ch.data = '0;
    clear_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1300);
    frame_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
